@@ hw/rtl/kvpe_pkg.sv @@
// Shared types and constants of the key/value pair extractor.
package kvpe_pkg;

  // Byte codes the scanner reacts to.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_BTICK  = 8'h60;

  // Closer kinds selected by the byte after '='.
  localparam int CK_W = 3;
  localparam logic [CK_W-1:0] CK_BLANK   = 3'd0;
  localparam logic [CK_W-1:0] CK_ANGLE   = 3'd1;
  localparam logic [CK_W-1:0] CK_PAREN   = 3'd2;
  localparam logic [CK_W-1:0] CK_BRACKET = 3'd3;
  localparam logic [CK_W-1:0] CK_DQUOTE  = 3'd4;
  localparam logic [CK_W-1:0] CK_SQUOTE  = 3'd5;
  localparam logic [CK_W-1:0] CK_TICK    = 3'd6;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = CFG_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_PREFIX_LENGTH = '0;
  localparam int PREFIX_W = 5;
  localparam logic [PREFIX_W-1:0] PREFIX_RESET = 5'd7;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_all;
    logic label_clear;
    logic label_push;
    logic dotted_clear;
    logic value_clear;
    logic value_push;
    logic closer_load;
    logic closer_clear;
    logic start_emit;
    logic emit_step;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic            is_zero;
    logic            is_eq;
    logic            is_white;
    logic [CK_W-1:0] opener;
    logic            closes;
    logic            closes_blank;
    logic            label_empty;
    logic            value_empty;
    logic            slot_free;
    logic            emit_last;
  } ctl_status_t;

endpackage

@@ hw/rtl/kvpe_ctrl.sv @@
// Controller of the key/value pair extractor: scan mode and emission sequencing.
module kvpe_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  kvpe_pkg::ctl_status_t stat,
  output kvpe_pkg::ctl_cmd_t    cmd
);
  import kvpe_pkg::*;

  localparam logic S_SCAN = 1'b0;
  localparam logic S_EMIT = 1'b1;

  logic state;
  logic state_next;
  logic mode;
  logic mode_next;
  logic just_opened;
  logic just_opened_next;
  logic closing;

  assign in_stall = (state == S_EMIT);

  // Right after '=' the closer is still the blank kind.
  assign closing = just_opened ? stat.closes_blank : stat.closes;

  always_comb begin
    cmd              = '0;
    state_next       = state;
    mode_next        = mode;
    just_opened_next = just_opened;
    case (state)
      S_SCAN: begin
        if (in_valid) begin
          if (!mode) begin
            if (stat.is_zero) begin
              cmd.clear_all = 1'b1;
            end else if (stat.is_eq) begin
              if (!stat.label_empty) begin
                mode_next        = 1'b1;
                just_opened_next = 1'b1;
                cmd.value_clear  = 1'b1;
                cmd.closer_clear = 1'b1;
              end else begin
                cmd.dotted_clear = 1'b1;
              end
            end else if (stat.is_white) begin
              cmd.label_clear  = 1'b1;
              cmd.dotted_clear = 1'b1;
            end else begin
              cmd.label_push = 1'b1;
            end
          end else if (just_opened && (stat.opener != CK_BLANK)) begin
            just_opened_next = 1'b0;
            cmd.closer_load  = 1'b1;
          end else begin
            just_opened_next = 1'b0;
            cmd.closer_clear = just_opened;
            if (closing) begin
              cmd.clear_all = 1'b1;
              mode_next     = 1'b0;
              if (!stat.value_empty) begin
                cmd.start_emit = 1'b1;
                state_next     = S_EMIT;
              end
            end else begin
              cmd.value_push = 1'b1;
            end
          end
        end
      end
      S_EMIT: begin
        cmd.emit_step = stat.slot_free;
        if (stat.slot_free && stat.emit_last) begin
          state_next = S_SCAN;
        end
      end
      default: begin
        state_next = S_SCAN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_SCAN;
      mode        <= 1'b0;
      just_opened <= 1'b0;
    end else begin
      state       <= state_next;
      mode        <= mode_next;
      just_opened <= just_opened_next;
    end
  end

  // Emission is only started from value mode.
  a_emit_from_value: assert property (@(posedge clk) disable iff (rst)
    cmd.start_emit |-> mode)
    else $error("emission started outside value mode");

  // After a pair starts emitting, no request is taken in the next cycle.
  a_stall_after_start: assert property (@(posedge clk) disable iff (rst)
    cmd.start_emit |=> in_stall)
    else $error("input not stalled during emission");

  // Just-opened is only set while reading a value.
  a_opened_in_value: assert property (@(posedge clk) disable iff (rst)
    just_opened |-> mode)
    else $error("just_opened set in label mode");

endmodule

@@ hw/rtl/kvpe_datapath.sv @@
// Datapath of the key/value pair extractor: byte classes, stores and output register.
module kvpe_datapath #(
  parameter int LABEL_MAX = 32,
  parameter int VALUE_MAX = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [7:0]                        in_byte,
  input  logic [kvpe_pkg::PREFIX_W-1:0]     prefix_length,
  input  kvpe_pkg::ctl_cmd_t                cmd,
  output kvpe_pkg::ctl_status_t             stat,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic [7:0]                        out_byte,
  output logic                              part,
  output logic                              prefix_wanted,
  output logic                              last
);
  import kvpe_pkg::*;

  localparam int LCW = $clog2(LABEL_MAX);
  localparam int LAW = $clog2(LABEL_MAX - 1);
  localparam int VCW = $clog2(VALUE_MAX);
  localparam int VAW = (VALUE_MAX > 2) ? $clog2(VALUE_MAX - 1) : 1;
  localparam int EW  = (LCW > VCW) ? LCW : VCW;
  localparam logic [LCW-1:0] LABEL_LIMIT = LCW'(LABEL_MAX - 1);
  localparam logic [VCW-1:0] VALUE_LIMIT = VCW'(VALUE_MAX - 1);
  localparam logic [LCW-1:0] PREFIX_CAP  = LCW'(LABEL_MAX / 2 + 1);

  logic [7:0]      label_mem [0:LABEL_MAX-2];
  logic [7:0]      value_mem [0:VALUE_MAX-2];
  logic [LCW-1:0]  label_count;
  logic            label_dotted;
  logic [VCW-1:0]  value_count;
  logic [CK_W-1:0] closer_kind;

  logic [LCW-1:0]  e_nl;
  logic [VCW-1:0]  e_nv;
  logic            epart;
  logic [EW-1:0]   eidx;
  logic            epw;

  logic [7:0]      label_rd;
  logic [7:0]      value_rd;
  logic            out_valid_r;
  logic            part_r;
  logic            last_r;
  logic            pw_r;

  logic            label_wr;
  logic            value_wr;
  logic [CK_W-1:0] opener;
  logic            closes_kind;
  logic [LCW-1:0]  p_ext;
  logic [LCW-1:0]  eff;
  logic [LCW-1:0]  room;
  logic [LCW-1:0]  nl;
  logic            emit_last;

  assign label_wr = cmd.label_push && (label_count != LABEL_LIMIT);
  assign value_wr = cmd.value_push && (value_count != VALUE_LIMIT);

  always_comb begin
    case (in_byte)
      CH_LT:     opener = CK_ANGLE;
      CH_LPAREN: opener = CK_PAREN;
      CH_LBRACK: opener = CK_BRACKET;
      CH_DQUOTE: opener = CK_DQUOTE;
      CH_SQUOTE: opener = CK_SQUOTE;
      CH_BTICK:  opener = CK_TICK;
      default:   opener = CK_BLANK;
    endcase
  end

  always_comb begin
    case (closer_kind)
      CK_ANGLE:   closes_kind = (in_byte == CH_GT);
      CK_PAREN:   closes_kind = (in_byte == CH_RPAREN);
      CK_BRACKET: closes_kind = (in_byte == CH_RBRACK);
      CK_DQUOTE:  closes_kind = (in_byte == CH_DQUOTE);
      CK_SQUOTE:  closes_kind = (in_byte == CH_SQUOTE);
      CK_TICK:    closes_kind = (in_byte == CH_BTICK) || (in_byte == CH_SQUOTE);
      default:    closes_kind = (in_byte == CH_SPACE) || (in_byte == CH_TAB);
    endcase
  end

  // Label room for the pair that is about to be emitted.
  assign p_ext = LCW'(prefix_length);
  assign eff   = (p_ext == '0) ? LCW'(1) : ((p_ext > PREFIX_CAP) ? PREFIX_CAP : p_ext);
  assign room  = label_dotted ? LABEL_LIMIT : (LABEL_LIMIT - eff);
  assign nl    = (label_count < room) ? label_count : room;

  assign emit_last = epart && (eidx == (EW'(e_nv) - EW'(1)));

  always_comb begin
    stat              = '0;
    stat.is_zero      = (in_byte == CH_NUL);
    stat.is_eq        = (in_byte == CH_EQ);
    stat.is_white     = (in_byte == CH_SPACE) || (in_byte == CH_TAB) || (in_byte == CH_LF) ||
                        (in_byte == CH_VT) || (in_byte == CH_FF) || (in_byte == CH_CR);
    stat.opener       = opener;
    stat.closes       = (in_byte == CH_NUL) || closes_kind;
    stat.closes_blank = (in_byte == CH_NUL) || (in_byte == CH_SPACE) || (in_byte == CH_TAB);
    stat.label_empty  = (label_count == '0);
    stat.value_empty  = (value_count == '0);
    stat.slot_free    = !out_valid_r || !out_stall;
    stat.emit_last    = emit_last;
  end

  // Stores.
  always_ff @(posedge clk) begin
    if (label_wr) begin
      label_mem[label_count[LAW-1:0]] <= in_byte;
    end
    if (value_wr) begin
      value_mem[value_count[VAW-1:0]] <= in_byte;
    end
    if (cmd.emit_step && !epart) begin
      label_rd <= label_mem[eidx[LAW-1:0]];
    end
    if (cmd.emit_step && epart) begin
      value_rd <= value_mem[eidx[VAW-1:0]];
    end
  end

  // Scan state.
  always_ff @(posedge clk) begin
    if (rst) begin
      label_count  <= '0;
      label_dotted <= 1'b0;
      value_count  <= '0;
      closer_kind  <= CK_BLANK;
    end else begin
      if (cmd.clear_all || cmd.label_clear) begin
        label_count <= '0;
      end else if (label_wr) begin
        label_count <= label_count + LCW'(1);
      end
      if (cmd.clear_all || cmd.dotted_clear) begin
        label_dotted <= 1'b0;
      end else if (cmd.label_push && (label_count == '0)) begin
        label_dotted <= (in_byte == CH_DOT);
      end
      if (cmd.clear_all || cmd.value_clear) begin
        value_count <= '0;
      end else if (value_wr) begin
        value_count <= value_count + VCW'(1);
      end
      if (cmd.clear_all || cmd.closer_clear) begin
        closer_kind <= CK_BLANK;
      end else if (cmd.closer_load) begin
        closer_kind <= opener;
      end
    end
  end

  // Emission counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      epart <= 1'b0;
      eidx  <= '0;
    end else if (cmd.start_emit) begin
      epart <= (nl == '0);
      eidx  <= '0;
    end else if (cmd.emit_step) begin
      if (!epart && (eidx == (EW'(e_nl) - EW'(1)))) begin
        epart <= 1'b1;
        eidx  <= '0;
      end else begin
        eidx <= eidx + EW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_emit) begin
      e_nl <= nl;
      e_nv <= value_count;
      epw  <= !label_dotted;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_step) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_step) begin
      part_r <= epart;
      last_r <= emit_last;
      pw_r   <= epw;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = part_r ? value_rd : label_rd;
  assign part          = part_r;
  assign prefix_wanted = pw_r;
  assign last          = last_r;

  // The final byte of a pair is always a value byte.
  a_last_is_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid_r && last_r) |-> part_r)
    else $error("last flag on a label byte");

  // A pair is only emitted with a non-empty value.
  a_start_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.start_emit |-> (value_count != '0))
    else $error("emission started with an empty value");

  // Counts never pass the store depth.
  a_count_bounds: assert property (@(posedge clk) disable iff (rst)
    (label_count <= LABEL_LIMIT) && (value_count <= VALUE_LIMIT))
    else $error("store count beyond its depth");

  // A new byte is never loaded over a result that is still held.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_step |-> (!out_valid_r || !out_stall))
    else $error("output register overwritten while stalled");

endmodule

@@ hw/rtl/key_value_pair_extractor.sv @@
// Top level of the key/value pair extractor: configuration register and block wiring.
// Output: a closing request with a non-empty value starts the emission of its pair.
// Throughput: one input request per cycle while scanning; a closing request that emits
// result bytes holds the input stalled until the last of them is loaded, paced by the
// output register and the single read port of each byte store.
// Reset: synchronous and active high; clears scan and emission state and sets
// prefix_length to 7. The byte stores are not cleared; only written entries are read.
module key_value_pair_extractor #(
  parameter int LABEL_MAX = 32,
  parameter int VALUE_MAX = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [kvpe_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [kvpe_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [kvpe_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      out_byte,
  output logic                            part,
  output logic                            prefix_wanted,
  output logic                            last
);
  import kvpe_pkg::*;

  logic [PREFIX_W-1:0] prefix_length;
  logic [REG_IDX_W-1:0] reg_idx;
  ctl_cmd_t            cmd;
  ctl_status_t         stat;

  // The port never inserts wait states. Registers sit on 32-bit word addresses,
  // so the low two address bits do not take part in decoding.
  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_W-1:2];

  // Write the prefix length only while the block is idle; the block does not enforce it.
  // It is the length of the service name plus its dot that a downstream stage puts in
  // front of labels without a leading dot, so it trims the room left for such labels.
  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_length <= PREFIX_RESET;
    end else if (psel && penable && pwrite && pready && (reg_idx == REG_PREFIX_LENGTH)) begin
      prefix_length <= pwdata[PREFIX_W-1:0];
    end
  end

  // Reads return the register, and zero at addresses where no register lies.
  always_comb begin
    case (reg_idx)
      REG_PREFIX_LENGTH: prdata = CFG_DATA_W'(prefix_length);
      default:           prdata = '0;
    endcase
  end

  // The controller decides, for each accepted request, which stores and counters change,
  // and sequences the emission of a closed pair, one byte per cycle when not stalled.
  kvpe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath classifies the incoming byte, holds the label and value stores with
  // their counts, and drives the registered output.
  kvpe_datapath #(
    .LABEL_MAX (LABEL_MAX),
    .VALUE_MAX (VALUE_MAX)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .in_byte       (in_byte),
    .prefix_length (prefix_length),
    .cmd           (cmd),
    .stat          (stat),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_byte      (out_byte),
    .part          (part),
    .prefix_wanted (prefix_wanted),
    .last          (last)
  );

endmodule

@@ sim/kvpe_pair_checker.sv @@
`timescale 1ns / 1ps
// Checker that predicts the emitted pair bytes of the key/value pair extractor and compares them.
module kvpe_pair_checker #(
  parameter int LABEL_MAX = 32,
  parameter int VALUE_MAX = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [kvpe_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [kvpe_pkg::CFG_DATA_W-1:0] pwdata,
  input  logic                            pready,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [7:0]                      in_byte,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [7:0]                      out_byte,
  input  logic                            part,
  input  logic                            prefix_wanted,
  input  logic                            last,
  output int                              failures,
  output int                              pending
);

  import kvpe_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       part;
    logic       prefix;
    logic       last;
  } pair_byte_t;

  pair_byte_t             pair_bytes_due[$];
  pair_byte_t             want;
  logic [PREFIX_W-1:0]    prefix_len;
  logic                   reading_value;
  logic                   after_eq;
  logic                   label_dot;
  logic [7:0]             label_bytes [LABEL_MAX];
  logic [7:0]             value_bytes [VALUE_MAX];
  int                     label_len;
  int                     value_len;
  logic [CK_W-1:0]        closer;
  int                     fail_total;

  function automatic bit is_blank(input logic [7:0] b);
    return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_VT ||
           b == CH_FF || b == CH_CR;
  endfunction

  // A zero byte closes any value; otherwise the opener chosen after '=' decides.
  function automatic bit ends_value(input logic [7:0] b);
    if (b == CH_NUL) return 1'b1;
    case (closer)
      CK_ANGLE:   return b == CH_GT;
      CK_PAREN:   return b == CH_RPAREN;
      CK_BRACKET: return b == CH_RBRACK;
      CK_DQUOTE:  return b == CH_DQUOTE;
      CK_SQUOTE:  return b == CH_SQUOTE;
      CK_TICK:    return b == CH_BTICK || b == CH_SQUOTE;
      default:    return b == CH_SPACE || b == CH_TAB;
    endcase
  endfunction

  function automatic void clear_scan();
    reading_value = 1'b0;
    after_eq      = 1'b0;
    label_dot     = 1'b0;
    label_len     = 0;
    value_len     = 0;
    closer        = CK_BLANK;
  endfunction

  // Labels without a leading dot lose room to the service prefix added downstream.
  function automatic void queue_pair_bytes();
    int room;
    int eff;
    int n_label;
    int total;
    pair_byte_t pb;
    if (label_dot) begin
      room = LABEL_MAX - 1;
    end else begin
      eff = prefix_len;
      if (eff < 1) eff = 1;
      if (eff > LABEL_MAX / 2 + 1) eff = LABEL_MAX / 2 + 1;
      room = LABEL_MAX - 1 - eff;
    end
    n_label = (label_len < room) ? label_len : room;
    total   = n_label + value_len;
    for (int k = 0; k < total; k++) begin
      pb.data   = (k < n_label) ? label_bytes[k] : value_bytes[k - n_label];
      pb.part   = (k >= n_label);
      pb.prefix = !label_dot;
      pb.last   = (k == total - 1);
      pair_bytes_due.push_back(pb);
    end
  endfunction

  function automatic void scan_byte(input logic [7:0] b);
    bit opened;
    opened = 1'b0;
    if (!reading_value) begin
      if (b == CH_NUL) begin
        clear_scan();
      end else if (b == CH_EQ) begin
        if (label_len > 0) begin
          reading_value = 1'b1;
          after_eq      = 1'b1;
          value_len     = 0;
          closer        = CK_BLANK;
        end else begin
          label_dot = 1'b0;
        end
      end else if (is_blank(b)) begin
        label_len = 0;
        label_dot = 1'b0;
      end else begin
        if (label_len == 0) label_dot = (b == CH_DOT);
        if (label_len < LABEL_MAX - 1) begin
          label_bytes[label_len] = b;
          label_len++;
        end
      end
    end else begin
      if (after_eq) begin
        after_eq = 1'b0;
        opened   = 1'b1;
        case (b)
          CH_LT:     closer = CK_ANGLE;
          CH_LPAREN: closer = CK_PAREN;
          CH_LBRACK: closer = CK_BRACKET;
          CH_DQUOTE: closer = CK_DQUOTE;
          CH_SQUOTE: closer = CK_SQUOTE;
          CH_BTICK:  closer = CK_TICK;
          default: begin
            closer = CK_BLANK;
            opened = 1'b0;
          end
        endcase
      end
      if (!opened) begin
        if (ends_value(b)) begin
          if (value_len > 0) queue_pair_bytes();
          clear_scan();
        end else if (value_len < VALUE_MAX - 1) begin
          value_bytes[value_len] = b;
          value_len++;
        end
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      pair_bytes_due.delete();
      prefix_len = PREFIX_RESET;
      fail_total = 0;
      clear_scan();
    end else begin
      if (psel && penable && pwrite && pready &&
          paddr[CFG_ADDR_W-1:2] == REG_PREFIX_LENGTH) begin
        prefix_len = pwdata[PREFIX_W-1:0];
      end
      if (in_valid && !in_stall) scan_byte(in_byte);
      if (out_valid && !out_stall) begin
        if (pair_bytes_due.size() == 0) begin
          $error("out_byte: no result expected, got %h", out_byte);
          fail_total++;
        end else begin
          want = pair_bytes_due.pop_front();
          if (out_byte !== want.data) begin
            $error("out_byte: expected %h, got %h", want.data, out_byte);
            fail_total++;
          end
          if (part !== want.part) begin
            $error("part: expected %b, got %b", want.part, part);
            fail_total++;
          end
          if (prefix_wanted !== want.prefix) begin
            $error("prefix_wanted: expected %b, got %b", want.prefix, prefix_wanted);
            fail_total++;
          end
          if (last !== want.last) begin
            $error("last: expected %b, got %b", want.last, last);
            fail_total++;
          end
        end
      end
    end
    failures <= fail_total;
    pending  <= pair_bytes_due.size();
  end

endmodule

@@ sim/tb_key_value_pair_extractor.sv @@
`timescale 1ns / 1ps
// Testbench top of the key/value pair extractor: clock, reset, stimulus and verdict.
module tb_key_value_pair_extractor;

  import kvpe_pkg::*;

  // A run fails if this many cycles pass in a row with no request, no result
  // and no register access. A pair emits at most 62 bytes and the random
  // stalls are short, so a correct block never comes near this.
  localparam int WATCHDOG_LIMIT = 2000;
  // Settling time after the last predicted result, with margin for requests still in flight.
  localparam int DRAIN_CYCLES   = 6;

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr     = '0;
  logic [CFG_DATA_W-1:0] pwdata    = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_byte   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [7:0]            out_byte;
  logic                  part;
  logic                  prefix_wanted;
  logic                  last;

  int                    failures;
  int                    pending;
  int                    sent = 0;
  int                    quiet_cycles = 0;
  // While steady is set, neither side inserts idle cycles.
  bit                    steady = 1'b0;

  // Directed opening message. It covers a dotted label with an angle-quoted value,
  // an '=' with no label, a vertical tab restarting the label, a parenthesized 0xFF
  // value, a 0x01 label with an empty bracketed value, a space closing an empty
  // unquoted value, and a zero byte right after '='.
  logic [7:0] opening_bytes [0:22] = '{
    CH_DOT, 8'h61, CH_EQ, CH_LT, 8'h78, CH_GT,
    CH_EQ, CH_VT,
    8'h62, CH_EQ, CH_LPAREN, 8'hFF, CH_RPAREN,
    8'h01, CH_EQ, CH_LBRACK, CH_RBRACK,
    8'h63, CH_EQ, CH_SPACE,
    8'h64, CH_EQ, CH_NUL
  };

  key_value_pair_extractor i_dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .part          (part),
    .prefix_wanted (prefix_wanted),
    .last          (last)
  );

  kvpe_pair_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .part          (part),
    .prefix_wanted (prefix_wanted),
    .last          (last),
    .failures      (failures),
    .pending       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The result side stalls in about a fifth of the cycles, except in the steady stretch.
  always @(negedge clk) begin
    out_stall <= !steady && ($urandom_range(0, 99) < 21);
  end

  // Watchdog: any handshake or register access restarts the count.
  always @(posedge clk) begin
    if (rst || psel || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Sends one request. Called at a falling edge and returns at a falling edge, so
  // valid is never lowered and raised within the same time step.
  task automatic put_byte(input logic [7:0] b);
    while (!steady && $urandom_range(0, 99) < 21) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    sent++;
  endtask

  // Register write: setup cycle, then access cycle until pready.
  task automatic write_prefix_length(input logic [PREFIX_W-1:0] v);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {REG_PREFIX_LENGTH, 2'b00};
    pwdata  <= CFG_DATA_W'(v);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Stops requests and waits until every predicted byte has come out. Requests
  // that emit nothing may still be in flight, so a few more cycles pass.
  task automatic drain();
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [7:0] any_white();
    case ($urandom_range(0, 5))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_LF;
      3:       return CH_VT;
      4:       return CH_FF;
      default: return CH_CR;
    endcase
  endfunction

  // A label byte is anything but zero, '=' or whitespace.
  function automatic logic [7:0] label_char();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(1, 255));
    end while (b == CH_EQ || b == CH_SPACE || b == CH_TAB || b == CH_LF ||
               b == CH_VT || b == CH_FF || b == CH_CR);
    return b;
  endfunction

  function automatic logic [7:0] opener_of(input logic [CK_W-1:0] kind);
    case (kind)
      CK_ANGLE:   return CH_LT;
      CK_PAREN:   return CH_LPAREN;
      CK_BRACKET: return CH_LBRACK;
      CK_DQUOTE:  return CH_DQUOTE;
      CK_SQUOTE:  return CH_SQUOTE;
      default:    return CH_BTICK;
    endcase
  endfunction

  function automatic logic [7:0] closer_of(input logic [CK_W-1:0] kind);
    case (kind)
      CK_ANGLE:   return CH_GT;
      CK_PAREN:   return CH_RPAREN;
      CK_BRACKET: return CH_RBRACK;
      CK_DQUOTE:  return CH_DQUOTE;
      CK_SQUOTE:  return CH_SQUOTE;
      CK_TICK:    return ($urandom_range(0, 1) != 0) ? CH_BTICK : CH_SQUOTE;
      default:    return ($urandom_range(0, 1) != 0) ? CH_SPACE : CH_TAB;
    endcase
  endfunction

  // A value byte that does not close the value. An unquoted value must also not
  // start with an opener, or that byte would be taken as one.
  function automatic logic [7:0] value_char(input logic [CK_W-1:0] kind, input bit first);
    logic [7:0] b;
    bit         bad;
    do begin
      b = 8'($urandom_range(1, 255));
      case (kind)
        CK_ANGLE:   bad = (b == CH_GT);
        CK_PAREN:   bad = (b == CH_RPAREN);
        CK_BRACKET: bad = (b == CH_RBRACK);
        CK_DQUOTE:  bad = (b == CH_DQUOTE);
        CK_SQUOTE:  bad = (b == CH_SQUOTE);
        CK_TICK:    bad = (b == CH_BTICK || b == CH_SQUOTE);
        default:    bad = (b == CH_SPACE || b == CH_TAB) ||
                          (first && (b == CH_LT || b == CH_LPAREN || b == CH_LBRACK ||
                                     b == CH_DQUOTE || b == CH_SQUOTE || b == CH_BTICK));
      endcase
    end while (bad);
    return b;
  endfunction

  // Length of a label or value: mostly short, now and then past the store limit
  // so that truncation is exercised.
  function automatic int pick_length(input int shortest);
    return ($urandom_range(0, 11) == 0) ? $urandom_range(28, 36)
                                         : $urandom_range(shortest, 8);
  endfunction

  // A well-formed label=value pair with random content and a random opener.
  // Once in a while the value is cut short by the end of the message.
  task automatic send_pair();
    logic [CK_W-1:0] kind;
    int              lab_len;
    int              val_len;
    lab_len = pick_length(1);
    for (int i = 0; i < lab_len; i++) begin
      put_byte((i == 0 && $urandom_range(0, 3) == 0) ? CH_DOT : label_char());
    end
    put_byte(CH_EQ);
    kind = CK_W'($urandom_range(0, 6));
    if (kind != CK_BLANK) put_byte(opener_of(kind));
    val_len = pick_length(0);
    for (int i = 0; i < val_len; i++) begin
      put_byte(value_char(kind, i == 0));
    end
    put_byte(($urandom_range(0, 7) == 0) ? CH_NUL : closer_of(kind));
  endtask

  // Broken sequences and plain noise.
  task automatic send_noise();
    int n;
    case ($urandom_range(0, 3))
      0: begin
        // The message ends right after '='.
        put_byte(label_char());
        put_byte(CH_EQ);
        put_byte(CH_NUL);
      end
      1: begin
        // An '=' with nothing before it, then a bare word.
        put_byte(CH_EQ);
        put_byte(label_char());
        put_byte(label_char());
      end
      2: begin
        // Whitespace in the middle of a label restarts it before the '='.
        put_byte(label_char());
        put_byte(any_white());
        put_byte(label_char());
        put_byte(CH_EQ);
        put_byte(value_char(CK_BLANK, 1'b1));
      end
      default: begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) put_byte(8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  task automatic send_message();
    int n;
    n = $urandom_range(1, 3);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) == 0) send_noise();
      else send_pair();
      put_byte(any_white());
    end
    put_byte(CH_NUL);
  endtask

  initial begin
    logic [PREFIX_W-1:0] prefix_plan [5];
    int                  target;
    // Both ends of the legal range, then values below and above it that the
    // block saturates, then one at random.
    prefix_plan = '{5'd17, 5'd1, 5'd0, 5'd31, PREFIX_W'($urandom_range(0, 31))};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // The opening message runs with the prefix length left at its reset value.
    foreach (opening_bytes[i]) put_byte(opening_bytes[i]);

    // Each phase ends on a whole message, so it runs somewhat past its target.
    for (int phase = 0; phase < 5; phase++) begin
      drain();
      write_prefix_length(prefix_plan[phase]);
      // The middle phase runs with no idling on either side.
      steady = (phase == 2);
      target = sent + 35;
      while (sent < target) send_message();
    end
    steady = 1'b0;
    drain();

    if (failures == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
